// ===== rtl/abrf_pkg.sv =====
// Shared constants, config register types and pixel helper functions.
package abrf_pkg;

   localparam int COORD_BITS = 16;
   localparam int XY_BITS    = 15;
   localparam int PIX_BITS   = 32;
   localparam int SIZE_BITS  = 15;
   localparam int SHIFT_BITS = 5;
   localparam int IDX_BITS   = 4;
   // Signed compare width: holds left+width without overflow.
   localparam int CMP_BITS   = ((COORD_BITS > XY_BITS + 1) ? COORD_BITS : XY_BITS + 1) + 2;

   localparam logic [IDX_BITS-1:0] CSR_FILL_COLOR  = IDX_BITS'(0);
   localparam logic [IDX_BITS-1:0] CSR_RECT_LEFT   = IDX_BITS'(1);
   localparam logic [IDX_BITS-1:0] CSR_RECT_TOP    = IDX_BITS'(2);
   localparam logic [IDX_BITS-1:0] CSR_RECT_WIDTH  = IDX_BITS'(3);
   localparam logic [IDX_BITS-1:0] CSR_RECT_HEIGHT = IDX_BITS'(4);
   localparam logic [IDX_BITS-1:0] CSR_RED_SHIFT   = IDX_BITS'(5);
   localparam logic [IDX_BITS-1:0] CSR_GREEN_SHIFT = IDX_BITS'(6);
   localparam logic [IDX_BITS-1:0] CSR_BLUE_SHIFT  = IDX_BITS'(7);

   localparam logic [SHIFT_BITS-1:0] RED_SHIFT_RST   = SHIFT_BITS'(16);
   localparam logic [SHIFT_BITS-1:0] GREEN_SHIFT_RST = SHIFT_BITS'(8);
   localparam logic [SHIFT_BITS-1:0] BLUE_SHIFT_RST  = SHIFT_BITS'(0);

   typedef struct packed {
      logic [PIX_BITS-1:0]          fill_color;
      logic signed [COORD_BITS-1:0] rect_left;
      logic signed [COORD_BITS-1:0] rect_top;
      logic [SIZE_BITS-1:0]         rect_width;
      logic [SIZE_BITS-1:0]         rect_height;
      logic [SHIFT_BITS-1:0]        red_shift;
      logic [SHIFT_BITS-1:0]        green_shift;
      logic [SHIFT_BITS-1:0]        blue_shift;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      fill_color:  '0,
      rect_left:   '0,
      rect_top:    '0,
      rect_width:  '0,
      rect_height: '0,
      red_shift:   RED_SHIFT_RST,
      green_shift: GREEN_SHIFT_RST,
      blue_shift:  BLUE_SHIFT_RST
   };

   function automatic logic [7:0] get_byte(input logic [PIX_BITS-1:0] word,
                                           input logic [SHIFT_BITS-1:0] sh);
      logic [PIX_BITS-1:0] t;
      t = word >> sh;
      return t[7:0];
   endfunction

   function automatic logic [PIX_BITS-1:0] put_byte(input logic [7:0] b,
                                                    input logic [SHIFT_BITS-1:0] sh);
      return PIX_BITS'(b) << sh;
   endfunction

   // floor(s/255) for s up to 255*255.
   function automatic logic [7:0] div255(input logic [15:0] s);
      logic [16:0] t;
      t = 17'(s) + 17'(s >> 8) + 17'd1;
      return t[15:8];
   endfunction

endpackage

// ===== rtl/alpha_blend_rect_fill_top.sv =====
// Top level of the rectangle alpha fill block.
//
// Request channel: drive start high with req_pix_x, req_pix_y and req_pixel_in;
// the word is taken at a rising edge where start is high and busy is low.
// busy is low whenever reset is low, so one word is taken every cycle that start is high.
// Response channel: rsp_valid strobes for one cycle with rsp_pixel_out and
// rsp_covered, once the word has passed the four register stages.
// The receiver must take it then; there is no back pressure.
// Throughput: one pixel per clock; latency is set by the four register stages
// (capture, coverage and channel extract, 8x8 multiplies, divide by 255 and
// repack).
// Config channel: csr_valid/csr_ready with csr_index and csr_wdata; write
// registers only while no pixels are in flight. Indexes above 7 are ignored.
// Reset (synchronous) empties the pipeline and loads config defaults:
// everything zero except red_shift 16 and green_shift 8.
module alpha_blend_rect_fill_top
   import abrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [XY_BITS-1:0]  req_pix_x,
   input  logic [XY_BITS-1:0]  req_pix_y,
   input  logic [PIX_BITS-1:0] req_pixel_in,
   output logic                rsp_valid,
   output logic [PIX_BITS-1:0] rsp_pixel_out,
   output logic                rsp_covered,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IDX_BITS-1:0] csr_index,
   input  logic [PIX_BITS-1:0] csr_wdata
);

   cfg_type cfg;

   // hold off requests only while reset is applied
   assign busy = reset;

   abrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   abrf_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (start && !busy),
      .in_x        (req_pix_x),
      .in_y        (req_pix_y),
      .in_pix      (req_pixel_in),
      .out_valid   (rsp_valid),
      .out_pix     (rsp_pixel_out),
      .out_covered (rsp_covered)
   );

endmodule

// ===== rtl/abrf_csr.sv =====
// Configuration register file for the rectangle, fill color and channel positions.
module abrf_csr
   import abrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IDX_BITS-1:0] csr_index,
   input  logic [PIX_BITS-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FILL_COLOR:  cfg_in.fill_color  = csr_wdata;
            CSR_RECT_LEFT:   cfg_in.rect_left   = signed'(csr_wdata[COORD_BITS-1:0]);
            CSR_RECT_TOP:    cfg_in.rect_top    = signed'(csr_wdata[COORD_BITS-1:0]);
            CSR_RECT_WIDTH:  cfg_in.rect_width  = csr_wdata[SIZE_BITS-1:0];
            CSR_RECT_HEIGHT: cfg_in.rect_height = csr_wdata[SIZE_BITS-1:0];
            CSR_RED_SHIFT:   cfg_in.red_shift   = csr_wdata[SHIFT_BITS-1:0];
            CSR_GREEN_SHIFT: cfg_in.green_shift = csr_wdata[SHIFT_BITS-1:0];
            CSR_BLUE_SHIFT:  cfg_in.blue_shift  = csr_wdata[SHIFT_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/abrf_pipe.sv =====
// Four-stage blend datapath: capture, coverage/extract, multiply, divide/pack.
module abrf_pipe
   import abrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   input  logic [XY_BITS-1:0]  in_x,
   input  logic [XY_BITS-1:0]  in_y,
   input  logic [PIX_BITS-1:0] in_pix,
   output logic                out_valid,
   output logic [PIX_BITS-1:0] out_pix,
   output logic                out_covered
);

   // stage 1: captured word
   logic                s1_valid_ff;
   logic [XY_BITS-1:0]  s1_x_ff, s1_y_ff;
   logic [PIX_BITS-1:0] s1_pix_ff;

   // stage 2: coverage and extracted channels
   logic                s2_valid_ff, s2_cover_ff, s2_cover_in;
   logic [PIX_BITS-1:0] s2_pix_ff;
   logic [7:0]          s2_r_ff, s2_g_ff, s2_b_ff;

   // stage 3: weighted sums
   logic                s3_valid_ff, s3_cover_ff;
   logic [PIX_BITS-1:0] s3_pix_ff;
   logic [15:0]         s3_r_ff, s3_g_ff, s3_b_ff;
   logic [15:0]         s3_r_in, s3_g_in, s3_b_in;

   // output stage
   logic                out_valid_ff, out_cover_ff;
   logic [PIX_BITS-1:0] out_pix_ff, out_pix_in;

   logic signed [CMP_BITS-1:0] x_ext, y_ext, left_ext, top_ext, right_ext, bottom_ext;
   logic [7:0] src_r, src_g, src_b, alpha, inv_alpha;

   always_comb begin
      x_ext      = signed'(CMP_BITS'(s1_x_ff));
      y_ext      = signed'(CMP_BITS'(s1_y_ff));
      left_ext   = CMP_BITS'(cfg.rect_left);
      top_ext    = CMP_BITS'(cfg.rect_top);
      right_ext  = left_ext + signed'(CMP_BITS'(cfg.rect_width));
      bottom_ext = top_ext + signed'(CMP_BITS'(cfg.rect_height));
      s2_cover_in = (x_ext >= left_ext) && (x_ext < right_ext) &&
                    (y_ext >= top_ext) && (y_ext < bottom_ext);
   end

   assign src_r     = cfg.fill_color[7:0];
   assign src_g     = cfg.fill_color[15:8];
   assign src_b     = cfg.fill_color[23:16];
   assign alpha     = cfg.fill_color[31:24];
   assign inv_alpha = 8'd255 - alpha;

   assign s3_r_in = 16'(s2_r_ff) * 16'(inv_alpha) + 16'(src_r) * 16'(alpha);
   assign s3_g_in = 16'(s2_g_ff) * 16'(inv_alpha) + 16'(src_g) * 16'(alpha);
   assign s3_b_in = 16'(s2_b_ff) * 16'(inv_alpha) + 16'(src_b) * 16'(alpha);

   // Repack covered words, overlapping channel positions OR together; uncovered words pass.
   always_comb begin
      if (s3_cover_ff) begin
         out_pix_in = put_byte(div255(s3_r_ff), cfg.red_shift) |
                      put_byte(div255(s3_g_ff), cfg.green_shift) |
                      put_byte(div255(s3_b_ff), cfg.blue_shift);
      end else begin
         out_pix_in = s3_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_cover_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
         out_cover_ff <= s3_valid_ff && s3_cover_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff     <= in_x;
      s1_y_ff     <= in_y;
      s1_pix_ff   <= in_pix;
      s2_cover_ff <= s2_cover_in;
      s2_pix_ff   <= s1_pix_ff;
      s2_r_ff     <= get_byte(s1_pix_ff, cfg.red_shift);
      s2_g_ff     <= get_byte(s1_pix_ff, cfg.green_shift);
      s2_b_ff     <= get_byte(s1_pix_ff, cfg.blue_shift);
      s3_cover_ff <= s2_cover_ff;
      s3_pix_ff   <= s2_pix_ff;
      s3_r_ff     <= s3_r_in;
      s3_g_ff     <= s3_g_in;
      s3_b_ff     <= s3_b_in;
      out_pix_ff  <= out_pix_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_pix     = out_pix_ff;
   assign out_covered = out_cover_ff;

endmodule

// ===== rtl/abrf_chk.sv =====
// Port-level checker for the rectangle alpha fill block, bound to the top level.
module abrf_chk
   import abrf_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [PIX_BITS-1:0] req_pixel_in,
   input logic                rsp_valid,
   input logic [PIX_BITS-1:0] rsp_pixel_out,
   input logic                rsp_covered
);

   // every word taken comes back as a response unless reset intervenes
   a_rsp_follows: assert property (@(posedge clock)
      (start && !busy && !reset) ##1 !reset ##1 !reset ##1 !reset |=> rsp_valid)
      else $error("accepted word produced no response");

   // no response without a word taken earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("response without request");

   // uncovered words pass through untouched
   a_passthru: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_covered) |-> rsp_pixel_out == $past(req_pixel_in, 4))
      else $error("uncovered pixel altered");

   a_cover_strobe: assert property (@(posedge clock)
      !rsp_valid |-> !rsp_covered)
      else $error("covered flag without response");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");

endmodule

bind alpha_blend_rect_fill_top abrf_chk u_abrf_chk (.*);

// ===== tb/tb_alpha_blend_rect_fill_top.sv =====
// Self-checking testbench for the rectangle alpha fill block.
`timescale 1ns / 100ps

module tb_alpha_blend_rect_fill_top;
   import abrf_pkg::*;

   localparam int PIPE_DEPTH  = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_COORD   = (1 << XY_BITS) - 1;

   typedef struct packed {
      logic [XY_BITS-1:0]  x;
      logic [XY_BITS-1:0]  y;
      logic [PIX_BITS-1:0] pixel;
      logic                covered;
   } blend_result_type;

   // Own copy of the fill registers; predicts each pixel and checks responses in order.
   class fill_scoreboard_type;
      logic [PIX_BITS-1:0]   fill;
      int                    left, top, wd, ht;
      logic [SHIFT_BITS-1:0] rsh, gsh, bsh;
      blend_result_type      expected_pixels[$];
      int                    errors;
      int                    n_pixels;
      int                    n_covered;

      function new();
         load_defaults();
         errors = 0;
         n_pixels = 0;
         n_covered = 0;
      endfunction

      function void load_defaults();
         fill = '0;
         left = 0;
         top = 0;
         wd = 0;
         ht = 0;
         rsh = RED_SHIFT_RST;
         gsh = GREEN_SHIFT_RST;
         bsh = BLUE_SHIFT_RST;
      endfunction

      function void apply_write(logic [IDX_BITS-1:0] idx, logic [PIX_BITS-1:0] data);
         case (idx)
            CSR_FILL_COLOR:  fill = data;
            CSR_RECT_LEFT:   left = int'($signed(data[COORD_BITS-1:0]));
            CSR_RECT_TOP:    top = int'($signed(data[COORD_BITS-1:0]));
            CSR_RECT_WIDTH:  wd = int'(data[SIZE_BITS-1:0]);
            CSR_RECT_HEIGHT: ht = int'(data[SIZE_BITS-1:0]);
            CSR_RED_SHIFT:   rsh = data[SHIFT_BITS-1:0];
            CSR_GREEN_SHIFT: gsh = data[SHIFT_BITS-1:0];
            CSR_BLUE_SHIFT:  bsh = data[SHIFT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] take_byte(logic [PIX_BITS-1:0] p, logic [SHIFT_BITS-1:0] sh);
         logic [PIX_BITS-1:0] t;
         t = p >> sh;
         return t[7:0];
      endfunction

      // Bits pushed past the top of the word drop off.
      function logic [PIX_BITS-1:0] place_byte(logic [7:0] b, logic [SHIFT_BITS-1:0] sh);
         logic [PIX_BITS-1:0] t;
         t = PIX_BITS'(b);
         return t << sh;
      endfunction

      function logic [7:0] mix_channel(logic [7:0] d, logic [7:0] s, logic [7:0] a);
         int t;
         t = int'(d) * (255 - int'(a)) + int'(s) * int'(a);
         return 8'(t / 255);
      endfunction

      function blend_result_type blend_pixel(logic [XY_BITS-1:0] x, logic [XY_BITS-1:0] y,
                                             logic [PIX_BITS-1:0] p);
         blend_result_type r;
         logic [7:0]       a, cr, cg, cb;
         a = fill[31:24];
         r.x = x;
         r.y = y;
         r.covered = int'(x) >= left && int'(x) < left + wd &&
                     int'(y) >= top && int'(y) < top + ht;
         if (!r.covered) begin
            r.pixel = p;
            return r;
         end
         cr = mix_channel(take_byte(p, rsh), fill[7:0], a);
         cg = mix_channel(take_byte(p, gsh), fill[15:8], a);
         cb = mix_channel(take_byte(p, bsh), fill[23:16], a);
         r.pixel = place_byte(cr, rsh) | place_byte(cg, gsh) | place_byte(cb, bsh);
         return r;
      endfunction

      function void note_pixel(logic [XY_BITS-1:0] x, logic [XY_BITS-1:0] y,
                               logic [PIX_BITS-1:0] p);
         blend_result_type r;
         r = blend_pixel(x, y, p);
         n_pixels++;
         if (r.covered)
            n_covered++;
         expected_pixels.push_back(r);
      endfunction

      function void check_result(logic [PIX_BITS-1:0] pixel, logic covered);
         blend_result_type e;
         if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: pixel %08h covered %0b", pixel, covered);
            return;
         end
         e = expected_pixels.pop_front();
         if (pixel !== e.pixel || covered !== e.covered) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at x=%0d y=%0d: expected pixel %08h covered %0b, got %08h %0b",
                        e.x, e.y, e.pixel, e.covered, pixel, covered);
         end
      endfunction

      function int pending_count();
         return expected_pixels.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [XY_BITS-1:0]  req_pix_x;
   logic [XY_BITS-1:0]  req_pix_y;
   logic [PIX_BITS-1:0] req_pixel_in;
   logic                rsp_valid;
   logic [PIX_BITS-1:0] rsp_pixel_out;
   logic                rsp_covered;
   logic                csr_valid;
   logic                csr_ready;
   logic [IDX_BITS-1:0] csr_index;
   logic [PIX_BITS-1:0] csr_wdata;

   fill_scoreboard_type board = new();
   int                  cycles = 0;
   int                  n_writes = 0;
   int                  n_settings = 0;

   alpha_blend_rect_fill_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pix_x     (req_pix_x),
      .req_pix_y     (req_pix_y),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_covered   (rsp_covered),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_pixel(req_pix_x, req_pix_y, req_pixel_in);
         if (rsp_valid)
            board.check_result(rsp_pixel_out, rsp_covered);
         if (csr_valid && csr_ready) begin
            board.apply_write(csr_index, csr_wdata);
            n_writes++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // Mostly back to back, sometimes a short pause, rarely a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Keep the register bits, fill everything above them with noise.
   function automatic logic [PIX_BITS-1:0] with_noise(logic [PIX_BITS-1:0] v, int bits);
      logic [PIX_BITS-1:0] mask;
      if (bits >= PIX_BITS)
         return v;
      mask = (PIX_BITS'(1) << bits) - 1;
      return (PIX_BITS'($urandom) & ~mask) | (v & mask);
   endfunction

   function automatic logic [XY_BITS-1:0] pick_coord(int base, int span);
      int c;
      if ($urandom_range(0, 9) < 7)
         c = base - 3 + int'($urandom_range(0, span + 5));
      else
         c = int'($urandom_range(0, MAX_COORD));
      if (c < 0)
         c = 0;
      if (c > MAX_COORD)
         c = MAX_COORD;
      return XY_BITS'(c);
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return 0;
      if (r == 1)
         return 32767;
      if (r == 2)
         return $urandom_range(0, 32767);
      return $urandom_range(1, 40);
   endfunction

   function automatic int pick_origin();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return -32768;
      if (r == 1)
         return 32767;
      if (r == 2)
         return int'($urandom_range(0, 65535)) - 32768;
      return int'($urandom_range(0, 220)) - 20;
   endfunction

   // Must be entered at a falling edge; returns at a falling edge with start still high.
   task automatic issue_pixel(input logic [XY_BITS-1:0] x, input logic [XY_BITS-1:0] y,
                              input logic [PIX_BITS-1:0] p, input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : idle_len();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_pix_x <= x;
      req_pix_y <= y;
      req_pixel_in <= p;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [IDX_BITS-1:0] idx, input logic [PIX_BITS-1:0] data);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Drop start, wait for every expected word, then let the pipeline empty.
   task automatic settle();
      start <= 1'b0;
      while (board.pending_count() > 0)
         @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   task automatic program_fill(input logic [31:0] fill, input int left, input int top,
                               input int wd, input int ht, input int rs, input int gs,
                               input int bs, input bit stray);
      settle();
      csr_write(CSR_FILL_COLOR, fill);
      csr_write(CSR_RECT_LEFT, with_noise(PIX_BITS'(left), COORD_BITS));
      csr_write(CSR_RECT_TOP, with_noise(PIX_BITS'(top), COORD_BITS));
      csr_write(CSR_RECT_WIDTH, with_noise(PIX_BITS'(wd), SIZE_BITS));
      csr_write(CSR_RECT_HEIGHT, with_noise(PIX_BITS'(ht), SIZE_BITS));
      csr_write(CSR_RED_SHIFT, with_noise(PIX_BITS'(rs), SHIFT_BITS));
      csr_write(CSR_GREEN_SHIFT, with_noise(PIX_BITS'(gs), SHIFT_BITS));
      csr_write(CSR_BLUE_SHIFT, with_noise(PIX_BITS'(bs), SHIFT_BITS));
      // Unmapped index: must leave every register alone.
      if (stray)
         csr_write(IDX_BITS'($urandom_range(8, 15)), PIX_BITS'($urandom));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   initial begin
      int          phase, k, r, rs, gs, bs, left, top, wd, ht;
      logic [31:0] fill;
      bit          streaming;

      reset = 1'b1;
      start = 1'b0;
      req_pix_x = '0;
      req_pix_y = '0;
      req_pixel_in = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: zero-sized rectangle covers nothing.
      issue_pixel(15'd0, 15'd0, 32'h0000_0000, 1'b0);
      issue_pixel(15'h7fff, 15'h7fff, 32'hffff_ffff, 1'b0);

      // Small rectangle, half alpha: probe each edge from both sides.
      program_fill(32'h80c0_4020, 10, 20, 5, 3, 16, 8, 0, 1'b1);
      issue_pixel(15'd10, 15'd20, 32'hffff_ffff, 1'b0);
      issue_pixel(15'd14, 15'd22, 32'h1234_5678, 1'b1);
      issue_pixel(15'd9, 15'd20, 32'hdead_beef, 1'b1);
      issue_pixel(15'd15, 15'd20, 32'h0bad_f00d, 1'b0);
      issue_pixel(15'd10, 15'd19, 32'h5555_aaaa, 1'b0);
      issue_pixel(15'd10, 15'd23, 32'haaaa_5555, 1'b1);

      // Most negative origin: the far edge stays below zero.
      program_fill(32'hff11_2233, -32768, -32768, 32767, 32767, 16, 8, 0, 1'b0);
      issue_pixel(15'd0, 15'd0, 32'h8765_4321, 1'b0);

      // Whole surface but the last column and row, zero alpha.
      program_fill(32'h00ff_ffff, 0, 0, 32767, 32767, 0, 8, 16, 1'b0);
      issue_pixel(15'd0, 15'd0, 32'hffff_ffff, 1'b0);
      issue_pixel(15'd32766, 15'd32766, 32'hff00_ff00, 1'b1);
      issue_pixel(15'h7fff, 15'd0, 32'h0f0f_0f0f, 1'b1);

      // Single corner pixel, full alpha, shifts past the top byte and overlapping.
      program_fill(32'hffa5_5a3c, 32767, 32767, 1, 1, 24, 31, 31, 1'b1);
      issue_pixel(15'h7fff, 15'h7fff, 32'h0000_0000, 1'b0);
      issue_pixel(15'h7fff, 15'h7fff, 32'hffff_ffff, 1'b1);

      // Zero width with a real height.
      program_fill(32'h7f00_ff00, 0, 0, 0, 5, 16, 8, 0, 1'b0);
      issue_pixel(15'd0, 15'd0, 32'hc3c3_c3c3, 1'b0);

      for (phase = 0; phase < 14; phase++) begin
         streaming = ($urandom_range(0, 3) == 0);
         fill = $urandom;
         r = $urandom_range(0, 7);
         if (r == 0)
            fill[31:24] = 8'h00;
         else if (r == 1)
            fill[31:24] = 8'hff;
         left = pick_origin();
         top = pick_origin();
         wd = pick_size();
         ht = pick_size();
         r = $urandom_range(0, 9);
         case (r)
            0: begin rs = 0;  gs = 8;  bs = 16; end
            1: begin rs = 0;  gs = 16; bs = 8;  end
            2: begin rs = 8;  gs = 0;  bs = 16; end
            3: begin rs = 8;  gs = 16; bs = 0;  end
            4: begin rs = 16; gs = 0;  bs = 8;  end
            5: begin rs = 16; gs = 8;  bs = 0;  end
            6: begin rs = 24; gs = 16; bs = 8;  end
            default: begin
               rs = $urandom_range(0, 31);
               gs = $urandom_range(0, 31);
               bs = $urandom_range(0, 31);
            end
         endcase
         program_fill(fill, left, top, wd, ht, rs, gs, bs, $urandom_range(0, 2) == 0);
         for (k = 0; k < 100; k++)
            issue_pixel(pick_coord(left, wd), pick_coord(top, ht), $urandom, streaming);
      end

      settle();
      $display("pixels checked: %0d, inside rectangle: %0d", board.n_pixels, board.n_covered);
      $display("register settings: %0d, register writes: %0d, mismatches: %0d",
               n_settings, n_writes, board.errors);
      if (board.errors == 0 && board.pending_count() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/abrf_pkg.sv
rtl/abrf_csr.sv
rtl/abrf_pipe.sv
rtl/alpha_blend_rect_fill_top.sv
rtl/abrf_chk.sv
tb/tb_alpha_blend_rect_fill_top.sv
